### rtl/core/crbc_pkg.sv
// Shared types and constants for the sector cache tag and replacement controller.
package crbc_pkg;

    // Most flush write-backs reported for one flush item
    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        CMD_READ    = 2'd0,
        CMD_WRITE   = 2'd1,
        CMD_FLUSH   = 2'd2,
        CMD_CLR_CNT = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd        command;
        logic [31:0] sector;
    } t_cmd_item;

    typedef struct packed {
        logic        hit;
        logic [5:0]  entry;
        logic        fill;
        logic        writeback;
        logic [31:0] writeback_sector;
        logic        zero_read;
        logic [31:0] hit_count;
        logic [31:0] miss_count;
        logic        last;
    } t_result;

    // One line of the tag memory
    typedef struct packed {
        logic        valid;
        logic        dirty;
        logic        used;
        logic [31:0] sector;
    } t_line;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_SWEEP,
        S_WRITE,
        S_FL_RD,
        S_FL_CHK,
        S_FL_END
    } t_state;

endpackage

### rtl/core/clock_replacement_block_cache_tags.sv
// Tag, clock replacement and flush controller of a fully associative write-back sector cache.
//
//  channel   valid         ready         payload       accepted when
//  command   i_in_valid    o_in_ready    i_in_data     i_in_valid && o_in_ready
//  result    o_out_valid   i_out_ready   o_out_data    o_out_valid && i_out_ready
//  config    i_cfg_valid   o_cfg_ready   i_cfg_data    i_cfg_valid && o_cfg_ready
//
// After reset a clearing pass zeroes every line of the tag memory; no item is taken then.
// One item at a time; every item passes an accept and a decode state. Access: tag scan
// (stops early on a hit), then, when every entry is valid, a clock sweep to the first entry
// with a clear use bit, plus the write state. Flush: a read and a check state per entry
// plus an end state. Counter clear and zero read need only accept and decode.
// A stalled result register holds the sequencer only where a new result must be produced.
module clock_replacement_block_cache_tags
    import crbc_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_cmd_item   i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_result     o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    localparam int AW = $clog2(ENTRIES);
    localparam int IW = AW + 1;
    localparam logic [IW-1:0] IDX_END  = IW'(ENTRIES);
    localparam logic [IW-1:0] IDX_LAST = IW'(ENTRIES - 1);

    // wrap-around increment of an entry index
    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] x);
        logic [AW-1:0] y;
        y = (x == AW'(ENTRIES - 1)) ? '0 : x + 1'b1;
        return y;
    endfunction

    // tag memory
    t_line         r_mem [ENTRIES];
    t_line         r_rdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_line         mem_wdata;

    // control and working registers
    t_state        r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_pend, n_pend;
    logic [AW-1:0] r_pidx, n_pidx;
    t_cmd          r_cmd, n_cmd;
    logic [31:0]   r_sec, n_sec;
    logic          r_free, n_free;
    logic [AW-1:0] r_free_idx, n_free_idx;
    logic          r_hit, n_hit;
    logic [AW-1:0] r_ent, n_ent;
    logic          r_wdirty, n_wdirty;
    logic          r_wb, n_wb;
    logic [31:0]   r_wb_sec, n_wb_sec;
    logic [AW-1:0] r_hand, n_hand;
    logic [31:0]   r_hitc, n_hitc;
    logic [31:0]   r_missc, n_missc;
    logic [31:0]   r_unalloc;
    logic          r_have, n_have;
    logic [AW-1:0] r_held_idx, n_held_idx;
    logic [31:0]   r_held_sec, n_held_sec;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_result       r_out, n_out;
    logic          r_ovalid;
    logic          emit;
    logic          slot_free;
    logic          issue;
    logic          dirty_hit;
    logic          fl_end;

    assign slot_free   = !r_ovalid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // sequencer: next state, memory controls, results
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_pend     = r_pend;
        n_pidx     = r_pidx;
        n_cmd      = r_cmd;
        n_sec      = r_sec;
        n_free     = r_free;
        n_free_idx = r_free_idx;
        n_hit      = r_hit;
        n_ent      = r_ent;
        n_wdirty   = r_wdirty;
        n_wb       = r_wb;
        n_wb_sec   = r_wb_sec;
        n_hand     = r_hand;
        n_hitc     = r_hitc;
        n_missc    = r_missc;
        n_have     = r_have;
        n_held_idx = r_held_idx;
        n_held_sec = r_held_sec;
        n_cnt      = r_cnt;
        n_out      = r_out;
        emit       = 1'b0;
        mem_re     = 1'b0;
        mem_raddr  = r_idx[AW-1:0];
        mem_we     = 1'b0;
        mem_waddr  = r_pidx;
        mem_wdata  = r_rdata;
        issue      = 1'b0;
        dirty_hit  = 1'b0;
        fl_end     = 1'b0;

        unique case (r_state)
            // zero every line once after reset
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[AW-1:0];
                mem_wdata = '0;
                n_idx     = r_idx + 1'b1;
                if (r_idx == IDX_LAST) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_in_data.command;
                    n_sec   = i_in_data.sector;
                    n_state = S_DISPATCH;
                end
            end

            S_DISPATCH: begin
                priority if (r_cmd == CMD_CLR_CNT) begin
                    n_hitc  = '0;
                    n_missc = '0;
                    n_state = S_IDLE;
                end else if (r_cmd == CMD_FLUSH) begin
                    n_idx   = '0;
                    n_have  = 1'b0;
                    n_cnt   = '0;
                    n_state = S_FL_RD;
                end else if (r_cmd == CMD_READ && r_sec == r_unalloc) begin
                    // unallocated sector reads as zeros, cache untouched
                    if (slot_free) begin
                        emit               = 1'b1;
                        n_out              = '0;
                        n_out.zero_read    = 1'b1;
                        n_out.hit_count    = r_hitc;
                        n_out.miss_count   = r_missc;
                        n_out.last         = 1'b1;
                        n_state            = S_IDLE;
                    end
                end else begin
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_free  = 1'b0;
                    n_state = S_SCAN;
                end
            end

            // pipelined tag search: issue entry r_idx, check entry r_pidx
            S_SCAN: begin
                issue     = (r_idx != IDX_END);
                mem_re    = issue;
                mem_raddr = r_idx[AW-1:0];
                if (r_pend && r_rdata.valid && r_rdata.sector == r_sec) begin
                    n_hit    = 1'b1;
                    n_ent    = r_pidx;
                    n_wdirty = r_rdata.dirty || (r_cmd == CMD_WRITE);
                    n_wb     = 1'b0;
                    n_wb_sec = '0;
                    n_state  = S_WRITE;
                end else begin
                    // later free entries override: highest index wins
                    if (r_pend && !r_rdata.valid) begin
                        n_free     = 1'b1;
                        n_free_idx = r_pidx;
                    end
                    n_pend = issue;
                    n_pidx = r_idx[AW-1:0];
                    if (issue) begin
                        n_idx = r_idx + 1'b1;
                    end
                    if (!issue && !r_pend) begin
                        n_hit    = 1'b0;
                        n_wb     = 1'b0;
                        n_wb_sec = '0;
                        n_wdirty = (r_cmd == CMD_WRITE);
                        if (r_free) begin
                            n_ent   = r_free_idx;
                            n_state = S_WRITE;
                        end else begin
                            n_idx   = {1'b0, f_next(r_hand)};
                            n_pend  = 1'b0;
                            n_state = S_SWEEP;
                        end
                    end
                end
            end

            // clock sweep: clear set use bits until a clear one is found
            S_SWEEP: begin
                mem_re    = 1'b1;
                mem_raddr = r_idx[AW-1:0];
                n_idx     = {1'b0, f_next(r_idx[AW-1:0])};
                n_pend    = 1'b1;
                n_pidx    = r_idx[AW-1:0];
                if (r_pend) begin
                    if (r_rdata.used) begin
                        mem_we         = 1'b1;
                        mem_waddr      = r_pidx;
                        mem_wdata      = r_rdata;
                        mem_wdata.used = 1'b0;
                    end else begin
                        n_ent    = r_pidx;
                        n_hand   = r_pidx;
                        n_wb     = r_rdata.dirty;
                        n_wb_sec = r_rdata.dirty ? r_rdata.sector : '0;
                        n_state  = S_WRITE;
                    end
                end
            end

            // install the line, bump a counter, present the result
            S_WRITE: begin
                if (slot_free) begin
                    mem_we           = 1'b1;
                    mem_waddr        = r_ent;
                    mem_wdata.valid  = 1'b1;
                    mem_wdata.dirty  = r_wdirty;
                    mem_wdata.used   = 1'b1;
                    mem_wdata.sector = r_sec;
                    if (r_hit) begin
                        n_hitc = (r_hitc == '1) ? r_hitc : r_hitc + 32'd1;
                    end else begin
                        n_missc = (r_missc == '1) ? r_missc : r_missc + 32'd1;
                    end
                    emit                   = 1'b1;
                    n_out.hit              = r_hit;
                    n_out.entry            = 6'(r_ent);
                    n_out.fill             = !r_hit;
                    n_out.writeback        = r_wb;
                    n_out.writeback_sector = r_wb_sec;
                    n_out.zero_read        = 1'b0;
                    n_out.hit_count        = n_hitc;
                    n_out.miss_count       = n_missc;
                    n_out.last             = 1'b1;
                    n_state                = S_IDLE;
                end
            end

            S_FL_RD: begin
                mem_re    = 1'b1;
                mem_raddr = r_idx[AW-1:0];
                n_state   = S_FL_CHK;
            end

            // one dirty line is held back so the final one can carry last
            S_FL_CHK: begin
                dirty_hit = r_rdata.valid && r_rdata.dirty;
                if (!(dirty_hit && r_have && !slot_free)) begin
                    if (dirty_hit) begin
                        if (r_have) begin
                            emit                   = 1'b1;
                            n_out                  = '0;
                            n_out.entry            = 6'(r_held_idx);
                            n_out.writeback        = 1'b1;
                            n_out.writeback_sector = r_held_sec;
                            n_out.hit_count        = r_hitc;
                            n_out.miss_count       = r_missc;
                        end
                        n_have     = 1'b1;
                        n_held_idx = r_idx[AW-1:0];
                        n_held_sec = r_rdata.sector;
                        n_cnt      = r_cnt + 1'b1;
                    end
                    fl_end = (r_idx == IDX_LAST) ||
                             (dirty_hit && r_cnt == CNT_W'(MAX_RESULTS - 1));
                    if (fl_end) begin
                        n_state = S_FL_END;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_FL_RD;
                    end
                end
            end

            S_FL_END: begin
                if (!r_have) begin
                    n_state = S_IDLE;
                end else if (slot_free) begin
                    emit                   = 1'b1;
                    n_out                  = '0;
                    n_out.entry            = 6'(r_held_idx);
                    n_out.writeback        = 1'b1;
                    n_out.writeback_sector = r_held_sec;
                    n_out.hit_count        = r_hitc;
                    n_out.miss_count       = r_missc;
                    n_out.last             = 1'b1;
                    n_have                 = 1'b0;
                    n_state                = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_idx     <= '0;
            r_pend    <= 1'b0;
            r_free    <= 1'b0;
            r_have    <= 1'b0;
            r_cnt     <= '0;
            r_hand    <= '0;
            r_hitc    <= '0;
            r_missc   <= '0;
            r_unalloc <= 32'hFFFF_FFFF;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
            r_free  <= n_free;
            r_have  <= n_have;
            r_cnt   <= n_cnt;
            r_hand  <= n_hand;
            r_hitc  <= n_hitc;
            r_missc <= n_missc;
            if (i_cfg_valid) begin
                r_unalloc <= i_cfg_data;
            end
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pidx     <= n_pidx;
        r_cmd      <= n_cmd;
        r_sec      <= n_sec;
        r_free_idx <= n_free_idx;
        r_hit      <= n_hit;
        r_ent      <= n_ent;
        r_wdirty   <= n_wdirty;
        r_wb       <= n_wb;
        r_wb_sec   <= n_wb_sec;
        r_held_idx <= n_held_idx;
        r_held_sec <= n_held_sec;
        r_out      <= n_out;
    end

    // a new result never overwrites one that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (!r_ovalid || i_out_ready))
        else $error("result register overwritten");

    // the two memory ports never meet on one line
    a_port_conflict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("read and write of the same line in one cycle");

    // a sweep only runs over a full cache
    a_sweep_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP && r_pend) |-> r_rdata.valid)
        else $error("clock sweep reached an invalid line");

    // a counted hit leaves a nonzero counter
    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE && emit && r_hit) |=> (r_hitc != '0))
        else $error("hit counter did not advance");

    // flush never reports more than its limit
    a_flush_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_RESULTS))
        else $error("flush result count past limit");

endmodule

### test/clock_replacement_block_cache_tags_test.sv
// Self-checking testbench for the sector cache tag and clock replacement controller.
`timescale 1ns / 1ps

module clock_replacement_block_cache_tags_test;
    import crbc_pkg::*;

    localparam int ENTRIES      = 64;
    localparam int DRAIN_CYCLES = 2 * ENTRIES + 16;
    localparam int STALL_LIMIT  = 4000;
    localparam int PHASE_ITEMS  = 48;
    localparam int POOL_SIZE    = 96;
    localparam int HOLD_AFTER   = 100;
    localparam int HOLD_CYCLES  = 400;

    // receiver stall modes
    localparam int RX_FREE    = 0;
    localparam int RX_MOSTLY  = 1;
    localparam int RX_SPARSE  = 2;
    localparam int RX_PATTERN = 3;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    t_cmd_item   in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_result     out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;

    // predicted tag store and policy state
    logic [31:0] line_tag   [ENTRIES];
    bit          line_valid [ENTRIES];
    bit          line_dirty [ENTRIES];
    bit          line_ref   [ENTRIES];
    int          hand_pos;
    logic [31:0] hits_seen;
    logic [31:0] misses_seen;
    logic [31:0] unalloc_cfg;

    t_cmd_item   cmd_backlog [$];
    t_result     due_results [$];
    logic [31:0] sector_pool [POOL_SIZE];

    int  cmds_issued   = 0;
    int  cmds_accepted = 0;
    int  errors        = 0;
    int  idle_cycles   = 0;
    bit  cmd_took      = 1'b0;
    int  gap_left      = 0;
    int  burst_left    = 0;
    int  rx_cycle      = 0;
    int  rx_mode       = RX_FREE;
    int  hold_left     = 0;
    bit  hold_done     = 1'b0;

    clock_replacement_block_cache_tags #(
        .ENTRIES(ENTRIES)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Work out the results of one accepted command and queue them
    task automatic predict_cache_step(input t_cmd_item it);
        t_result r;
        int      slot;
        int      free_slot;
        int      last_dirty;
        bit      found;
        bit      have_free;
        r = '0;
        case (it.command)
            CMD_CLR_CNT: begin
                hits_seen   = '0;
                misses_seen = '0;
            end
            CMD_FLUSH: begin
                last_dirty = -1;
                for (int i = 0; i < ENTRIES; i++)
                    if (line_valid[i] && line_dirty[i]) last_dirty = i;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (line_valid[i] && line_dirty[i]) begin
                        r = '0;
                        r.entry            = i[5:0];
                        r.writeback        = 1'b1;
                        r.writeback_sector = line_tag[i];
                        r.hit_count        = hits_seen;
                        r.miss_count       = misses_seen;
                        r.last             = (i == last_dirty);
                        due_results.push_back(r);
                    end
                end
            end
            default: begin
                if (it.command == CMD_READ && it.sector == unalloc_cfg) begin
                    // zero-fill read, cache untouched
                    r.zero_read  = 1'b1;
                    r.hit_count  = hits_seen;
                    r.miss_count = misses_seen;
                    r.last       = 1'b1;
                    due_results.push_back(r);
                end else begin
                    found     = 1'b0;
                    have_free = 1'b0;
                    slot      = 0;
                    free_slot = 0;
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (!line_valid[i]) begin
                            have_free = 1'b1;
                            free_slot = i;
                        end else if (line_tag[i] == it.sector) begin
                            found = 1'b1;
                            slot  = i;
                            break;
                        end
                    end
                    if (found) begin
                        if (hits_seen != '1) hits_seen = hits_seen + 1;
                    end else begin
                        if (misses_seen != '1) misses_seen = misses_seen + 1;
                        if (have_free) begin
                            slot = free_slot;
                        end else begin
                            // clock sweep: step first, clear set use bits
                            hand_pos = (hand_pos + 1) % ENTRIES;
                            while (line_ref[hand_pos]) begin
                                line_ref[hand_pos] = 1'b0;
                                hand_pos = (hand_pos + 1) % ENTRIES;
                            end
                            slot = hand_pos;
                            if (line_dirty[slot]) begin
                                r.writeback        = 1'b1;
                                r.writeback_sector = line_tag[slot];
                                line_dirty[slot]   = 1'b0;
                            end
                        end
                        line_tag[slot]   = it.sector;
                        line_valid[slot] = 1'b1;
                    end
                    line_ref[slot] = 1'b1;
                    if (it.command == CMD_WRITE) line_dirty[slot] = 1'b1;
                    r.hit        = found;
                    r.entry      = slot[5:0];
                    r.fill       = !found;
                    r.hit_count  = hits_seen;
                    r.miss_count = misses_seen;
                    r.last       = 1'b1;
                    due_results.push_back(r);
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: field %s expected %0h got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Monitor: result checks, command prediction, stall watchdog
    always @(posedge i_clk) begin
        t_result want;
        if (out_valid && out_ready) begin
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, out_data);
                errors++;
            end else begin
                want = due_results.pop_front();
                check_field("hit", 32'(want.hit), 32'(out_data.hit));
                check_field("entry", 32'(want.entry), 32'(out_data.entry));
                check_field("fill", 32'(want.fill), 32'(out_data.fill));
                check_field("writeback", 32'(want.writeback), 32'(out_data.writeback));
                check_field("writeback_sector", want.writeback_sector,
                            out_data.writeback_sector);
                check_field("zero_read", 32'(want.zero_read), 32'(out_data.zero_read));
                check_field("hit_count", want.hit_count, out_data.hit_count);
                check_field("miss_count", want.miss_count, out_data.miss_count);
                check_field("last", 32'(want.last), 32'(out_data.last));
            end
        end
        cmd_took = in_valid && in_ready;
        if (cmd_took) begin
            predict_cache_step(in_data);
            cmds_accepted++;
        end
        if (cmd_took || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("[clock_replacement_block_cache_tags] ERROR");
            $finish;
        end
    end

    // Driver: bursts of commands separated by random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || cmd_took) begin
            if (burst_left == 0) begin
                gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
                burst_left = $urandom_range(1, 16);
            end
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (cmd_backlog.size() > 0) begin
                in_data  <= cmd_backlog.pop_front();
                in_valid <= 1'b1;
                burst_left--;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: changing stall modes plus one long hold-off
    always @(negedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 50 == 0) rx_mode = $urandom_range(RX_FREE, RX_PATTERN);
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (!hold_done && cmds_accepted >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            out_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_FREE:   out_ready <= 1'b1;
                RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
                RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                default:   out_ready <= ((rx_cycle % 5) < 3);
            endcase
        end
    end

    task automatic issue(input t_cmd c, input logic [31:0] s);
        t_cmd_item it;
        it.command = c;
        it.sector  = s;
        cmd_backlog.push_back(it);
        cmds_issued++;
    endtask

    // Mostly pooled sectors so the cache fills, hits, and sweeps
    task automatic issue_random();
        int          pick;
        t_cmd        c;
        logic [31:0] s;
        pick = $urandom_range(0, 99);
        c    = ($urandom_range(0, 4) < 2) ? CMD_WRITE : CMD_READ;
        s    = sector_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (pick < 3) begin
            c = CMD_FLUSH;
            s = $urandom;
        end else if (pick < 6) begin
            c = CMD_CLR_CNT;
            s = $urandom;
        end else if (pick < 11) begin
            c = CMD_READ;
            s = unalloc_cfg;
        end else if (pick < 14) begin
            c = CMD_WRITE;
            s = unalloc_cfg;
        end else if (pick < 20) begin
            s = $urandom;
        end
        issue(c, s);
    endtask

    task automatic refill_pool();
        for (int i = 0; i < POOL_SIZE; i++) sector_pool[i] = $urandom;
        sector_pool[0] = '0;
        sector_pool[1] = '1;
    endtask

    // Wait until every command is taken and every result is back
    task automatic wait_quiet();
        do @(negedge i_clk);
        while (cmds_accepted != cmds_issued || due_results.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_unalloc(input logic [31:0] v);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge i_clk);
        while (!(cfg_valid && cfg_ready));
        unalloc_cfg = v;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Stimulus sequence
    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            line_tag[i]   = '0;
            line_valid[i] = 1'b0;
            line_dirty[i] = 1'b0;
            line_ref[i]   = 1'b0;
        end
        hand_pos    = 0;
        hits_seen   = '0;
        misses_seen = '0;
        unalloc_cfg = '1;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty flush, unallocated sector, hits, repeated flush
        issue(CMD_FLUSH, 32'h0000_0000);
        issue(CMD_CLR_CNT, 32'hFFFF_FFFF);
        issue(CMD_READ, 32'hFFFF_FFFF);
        issue(CMD_WRITE, 32'hFFFF_FFFF);
        issue(CMD_READ, 32'hFFFF_FFFF);
        issue(CMD_READ, 32'h0000_0000);
        issue(CMD_WRITE, 32'h0000_0000);
        issue(CMD_READ, 32'h0000_0000);
        issue(CMD_FLUSH, 32'h1234_5678);
        issue(CMD_CLR_CNT, 32'h0000_0000);
        issue(CMD_FLUSH, 32'hFFFF_FFFF);
        issue(CMD_READ, 32'h5555_5555);
        issue(CMD_WRITE, 32'hAAAA_AAAA);
        issue(CMD_READ, 32'h8000_0000);
        issue(CMD_WRITE, 32'h7FFF_FFFF);
        issue(CMD_WRITE, 32'h0000_0001);
        issue(CMD_READ, 32'hAAAA_AAAA);
        issue(CMD_FLUSH, 32'h0000_0000);
        wait_quiet();

        // random phases, each under its own unallocated sector
        for (int ph = 0; ph < 4; ph++) begin
            refill_pool();
            case (ph)
                0:       write_unalloc(32'h0000_0000);
                1:       write_unalloc($urandom);
                2:       write_unalloc(32'hFFFF_FFFF);
                default: write_unalloc(sector_pool[$urandom_range(2, POOL_SIZE - 1)]);
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) issue_random();
            wait_quiet();
        end

        if (errors == 0 && due_results.size() == 0) begin
            $display("[clock_replacement_block_cache_tags] OK");
        end else begin
            $display("[clock_replacement_block_cache_tags] ERROR");
        end
        $finish;
    end

endmodule
